// ===== rtl/grns_pkg.sv =====
package grns_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // field widths of the channels
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 8'd1;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_VCLR,
    ST_SEED,
    ST_POP,
    ST_PWAIT,
    ST_RADDR,
    ST_RCHK,
    ST_EADDR,
    ST_ECHK
  } state_e;

  // road probe order: y+1, y-1, x+1, x-1
  function automatic logic signed [1:0] road_dx(input logic [1:0] k);
    case (k)
      2'd2:    road_dx = 2'sd1;
      2'd3:    road_dx = -2'sd1;
      default: road_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] road_dy(input logic [1:0] k);
    case (k)
      2'd0:    road_dy = 2'sd1;
      2'd1:    road_dy = -2'sd1;
      default: road_dy = 2'sd0;
    endcase
  endfunction

  // expansion order over the eight neighbours
  function automatic logic signed [1:0] exp_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd4, 3'd5: exp_dx = 2'sd1;
      3'd2, 3'd6, 3'd7: exp_dx = -2'sd1;
      default:          exp_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] exp_dy(input logic [2:0] k);
    case (k)
      3'd3, 3'd4, 3'd7: exp_dy = 2'sd1;
      3'd1, 3'd5, 3'd6: exp_dy = -2'sd1;
      default:          exp_dy = 2'sd0;
    endcase
  endfunction

  // (a + b) mod 3 for a in 0..2, b in 0..2
  function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 3'd3) s = s - 3'd3;
    add_mod3 = s[1:0];
  endfunction

endpackage

// ===== rtl/grns_if.sv =====
interface grns_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [grns_pkg::COORD_W-1:0]      cell_x;
  logic [grns_pkg::COORD_W-1:0]      cell_y;
  logic                              cell_open;
  logic                              cell_road;

  modport source (output valid, req_type, cell_x, cell_y, cell_open, cell_road,
                  input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, cell_open, cell_road,
                  output ready);
endinterface

interface grns_res_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [grns_pkg::COORD_W-1:0]      road_x;
  logic [grns_pkg::COORD_W-1:0]      road_y;

  modport source (output valid, found, road_x, road_y, input ready);
  modport sink   (input valid, found, road_x, road_y, output ready);
endinterface

interface grns_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [grns_pkg::CFG_IDX_W-1:0]    index;
  logic [grns_pkg::DIM_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/grns_ram.sv =====
module grns_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/grid_nearest_road_search_top.sv =====
// grid nearest road search
// req_i carries one transaction per map write or search. req_type write stores
// the open and road bits of one cell; req_type search runs a
// least-cost search from (cell_x, cell_y) and returns one transaction on res_o
// with found and the road cell coordinates (zero when nothing was reached).
// cfg_i sets map_width (index 0) and map_height (index 1); it is always ready
// and must be written only while the block is idle; the block does not enforce it.
// a search first clears the visited store, then takes each expanded cell in
// turn: it fetches the cell from the frontier in the pop and wait states, then
// runs the four road probes, ending on the first road hit, then the eight
// expansion probes, each probe being an address state and a check state on
// the single map read port.
// the frontier is three fifo buckets indexed by cost mod 3, since live costs
// span at most the popped cost plus two; this keeps insertion order on ties.
// after reset a clearing pass over every cell of the store zeroes the map;
// req_i is not ready during it. req_i is also not ready while a result waits
// on a stalled res_o or a search is running.
module grid_nearest_road_search_top #(
  parameter int unsigned MAX_WIDTH  = grns_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = grns_pkg::MAX_HEIGHT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  grns_req_if.sink   req_i,
  grns_res_if.source res_o,
  grns_cfg_if.sink   cfg_i
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned IW    = $clog2(CELLS);
  localparam int unsigned XW    = ($clog2(MAX_WIDTH) > 6) ? $clog2(MAX_WIDTH) : 6;
  localparam int unsigned YW    = ($clog2(MAX_HEIGHT) > 6) ? $clog2(MAX_HEIGHT) : 6;
  localparam int unsigned SXW   = XW + 2;
  localparam int unsigned SYW   = YW + 2;
  localparam int unsigned PW    = $clog2(CELLS + 1);
  localparam int unsigned BD    = 2 ** PW;
  localparam int unsigned EW    = XW + YW;
  localparam int unsigned WXW   = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
  localparam int unsigned WYW   = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;
  localparam int unsigned CXW   = (WXW > XW + 1) ? WXW : XW + 1;
  localparam int unsigned CYW   = (WYW > YW + 1) ? WYW : YW + 1;

  function automatic logic [IW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
    cell_idx = IW'(y) * IW'(MAX_WIDTH) + IW'(x);
  endfunction

  grns_pkg::state_e state_q, state_d;

  logic [grns_pkg::DIM_W-1:0] mapw_q, maph_q;
  logic [IW-1:0]              clr_q;
  logic [2:0]                 k_q;
  logic [1:0]                 cb_q, pb_q;
  logic [XW-1:0]              px_q, nxs_q;
  logic [YW-1:0]              py_q, nys_q;
  logic [grns_pkg::COORD_W-1:0] sx_q, sy_q;
  logic                       inmap_q;
  logic [IW-1:0]              idx_q;
  logic [1:0]                 dcost_q;
  logic [PW-1:0]              rdp_q [3];
  logic [PW-1:0]              wrp_q [3];
  logic                       out_valid_q, out_found_q;
  logic [grns_pkg::COORD_W-1:0] out_x_q, out_y_q;

  // handshakes
  logic req_acc, res_acc;
  assign req_i.ready = (state_q == grns_pkg::ST_IDLE) && !out_valid_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign res_acc     = res_o.valid && res_o.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid  = out_valid_q;
  assign res_o.found  = out_found_q;
  assign res_o.road_x = out_x_q;
  assign res_o.road_y = out_y_q;

  // bounds of the map in use, clipped to the store
  logic [WXW-1:0] wlim;
  logic [WYW-1:0] hlim;
  assign wlim = (WXW'(mapw_q) > WXW'(MAX_WIDTH)) ? WXW'(MAX_WIDTH) : WXW'(mapw_q);
  assign hlim = (WYW'(maph_q) > WYW'(MAX_HEIGHT)) ? WYW'(MAX_HEIGHT) : WYW'(maph_q);

  // shared neighbour unit: offset, bounds test and cell index
  logic              road_phase;
  logic signed [1:0] dx, dy;
  logic signed [SXW-1:0] nx;
  logic signed [SYW-1:0] ny;
  logic              nb_inmap;
  logic [IW-1:0]     nb_idx;

  assign road_phase = (state_q == grns_pkg::ST_RADDR);
  assign dx = road_phase ? grns_pkg::road_dx(k_q[1:0]) : grns_pkg::exp_dx(k_q);
  assign dy = road_phase ? grns_pkg::road_dy(k_q[1:0]) : grns_pkg::exp_dy(k_q);
  assign nx = $signed({2'b00, px_q}) + SXW'(dx);
  assign ny = $signed({2'b00, py_q}) + SYW'(dy);
  assign nb_inmap = !nx[SXW-1] && !ny[SYW-1] &&
                    (CXW'(nx[SXW-2:0]) < CXW'(wlim)) &&
                    (CYW'(ny[SYW-2:0]) < CYW'(hlim));
  assign nb_idx = cell_idx(nx[XW-1:0], ny[YW-1:0]);

  // map store {open, road}
  logic          map_we;
  logic [IW-1:0] map_waddr;
  logic [1:0]    map_wdata, map_rdata;
  logic          wr_in_store;

  assign wr_in_store = (int'(req_i.cell_x) < MAX_WIDTH) && (int'(req_i.cell_y) < MAX_HEIGHT);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = 2'b00;
    if (state_q == grns_pkg::ST_CLR) begin
      map_we = 1'b1;
    end else if (req_acc && req_i.req_type == grns_pkg::REQ_WRITE && wr_in_store) begin
      map_we    = 1'b1;
      map_waddr = cell_idx(XW'(req_i.cell_x), YW'(req_i.cell_y));
      map_wdata = {req_i.cell_open, req_i.cell_road};
    end
  end

  grns_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (nb_idx),
    .rdata_o (map_rdata)
  );

  // visited store
  logic          vis_we, vis_wdata, vis_rdata;
  logic [IW-1:0] vis_waddr;
  logic          start_in_store;
  logic          push_ok;

  assign start_in_store = (int'(sx_q) < MAX_WIDTH) && (int'(sy_q) < MAX_HEIGHT);
  assign push_ok = (state_q == grns_pkg::ST_ECHK) && inmap_q && map_rdata[1] && !vis_rdata;

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_q;
    vis_wdata = 1'b0;
    case (state_q)
      grns_pkg::ST_VCLR: vis_we = 1'b1;
      grns_pkg::ST_SEED: begin
        vis_we    = start_in_store;
        vis_waddr = cell_idx(XW'(sx_q), YW'(sy_q));
        vis_wdata = 1'b1;
      end
      grns_pkg::ST_ECHK: begin
        vis_we    = push_ok;
        vis_waddr = idx_q;
        vis_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  grns_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (nb_idx),
    .rdata_o (vis_rdata)
  );

  // frontier buckets, one fifo per cost mod 3
  logic [1:0]    push_b;
  logic          push_en;
  logic [EW-1:0] push_data;
  logic [EW-1:0] b_rdata [3];
  logic [2:0]    b_ne;

  always_comb begin
    push_en   = 1'b0;
    push_b    = 2'd0;
    push_data = {nys_q, nxs_q};
    if (state_q == grns_pkg::ST_SEED) begin
      push_en   = 1'b1;
      push_data = {YW'(sy_q), XW'(sx_q)};
    end else if (push_ok) begin
      push_en = 1'b1;
      push_b  = grns_pkg::add_mod3(pb_q, dcost_q);
    end
  end

  for (genvar b = 0; b < 3; b++) begin : g_bucket
    assign b_ne[b] = (rdp_q[b] != wrp_q[b]);
    grns_ram #(.WIDTH(EW), .DEPTH(BD)) u_bucket (
      .clk_i   (clk_i),
      .we_i    (push_en && (push_b == 2'(b))),
      .waddr_i (wrp_q[b]),
      .wdata_i (push_data),
      .raddr_i (rdp_q[b]),
      .rdata_o (b_rdata[b])
    );
  end

  // least cost bucket that holds an entry
  logic [1:0] c1, c2, sel_b;
  logic       any_ne;
  assign c1 = grns_pkg::add_mod3(cb_q, 2'd1);
  assign c2 = grns_pkg::add_mod3(cb_q, 2'd2);
  assign any_ne = b_ne[cb_q] || b_ne[c1] || b_ne[c2];
  assign sel_b  = b_ne[cb_q] ? cb_q : (b_ne[c1] ? c1 : c2);

  logic road_hit;
  assign road_hit = inmap_q && map_rdata[0];

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      grns_pkg::ST_CLR:   if (clr_q == IW'(CELLS - 1)) state_d = grns_pkg::ST_IDLE;
      grns_pkg::ST_IDLE:
        if (req_acc && req_i.req_type == grns_pkg::REQ_SEARCH) state_d = grns_pkg::ST_VCLR;
      grns_pkg::ST_VCLR:  if (clr_q == IW'(CELLS - 1)) state_d = grns_pkg::ST_SEED;
      grns_pkg::ST_SEED:  state_d = grns_pkg::ST_POP;
      grns_pkg::ST_POP:   state_d = any_ne ? grns_pkg::ST_PWAIT : grns_pkg::ST_IDLE;
      grns_pkg::ST_PWAIT: state_d = grns_pkg::ST_RADDR;
      grns_pkg::ST_RADDR: state_d = grns_pkg::ST_RCHK;
      grns_pkg::ST_RCHK: begin
        if (road_hit)            state_d = grns_pkg::ST_IDLE;
        else if (k_q[1:0] == 2'd3) state_d = grns_pkg::ST_EADDR;
        else                     state_d = grns_pkg::ST_RADDR;
      end
      grns_pkg::ST_EADDR: state_d = grns_pkg::ST_ECHK;
      grns_pkg::ST_ECHK:  state_d = (k_q == 3'd7) ? grns_pkg::ST_POP : grns_pkg::ST_EADDR;
      default:            state_d = grns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grns_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapw_q      <= grns_pkg::DIM_W'(64);
      maph_q      <= grns_pkg::DIM_W'(64);
      clr_q       <= '0;
      k_q         <= '0;
      cb_q        <= '0;
      pb_q        <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < 3; b++) begin
        rdp_q[b] <= '0;
        wrp_q[b] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == grns_pkg::REG_MAP_WIDTH)  mapw_q <= cfg_i.data;
        if (cfg_i.index == grns_pkg::REG_MAP_HEIGHT) maph_q <= cfg_i.data;
      end
      if (res_acc) out_valid_q <= 1'b0;
      if (push_en) wrp_q[push_b] <= wrp_q[push_b] + 1'b1;

      case (state_q)
        grns_pkg::ST_CLR, grns_pkg::ST_VCLR: clr_q <= clr_q + 1'b1;
        grns_pkg::ST_IDLE: begin
          clr_q <= '0;
          cb_q  <= '0;
          for (int b = 0; b < 3; b++) begin
            rdp_q[b] <= '0;
            wrp_q[b] <= '0;
          end
        end
        grns_pkg::ST_POP: begin
          if (any_ne) begin
            cb_q <= sel_b;
            pb_q <= sel_b;
            rdp_q[sel_b] <= rdp_q[sel_b] + 1'b1;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        grns_pkg::ST_PWAIT: k_q <= '0;
        grns_pkg::ST_RCHK: begin
          if (road_hit) out_valid_q <= 1'b1;
          else if (k_q[1:0] == 2'd3) k_q <= '0;
          else k_q <= k_q + 1'b1;
        end
        grns_pkg::ST_ECHK: k_q <= k_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      sx_q <= req_i.cell_x;
      sy_q <= req_i.cell_y;
    end
    if (state_q == grns_pkg::ST_PWAIT) begin
      px_q <= b_rdata[pb_q][XW-1:0];
      py_q <= b_rdata[pb_q][EW-1:XW];
    end
    if (state_q == grns_pkg::ST_RADDR || state_q == grns_pkg::ST_EADDR) begin
      nxs_q   <= nx[XW-1:0];
      nys_q   <= ny[YW-1:0];
      inmap_q <= nb_inmap;
      idx_q   <= nb_idx;
      dcost_q <= {1'b0, dx != 2'sd0} + {1'b0, dy != 2'sd0};
    end
    if (state_q == grns_pkg::ST_POP && !any_ne) begin
      out_found_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end
    if (state_q == grns_pkg::ST_RCHK && road_hit) begin
      out_found_q <= 1'b1;
      out_x_q     <= nxs_q[grns_pkg::COORD_W-1:0];
      out_y_q     <= nys_q[grns_pkg::COORD_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == grns_pkg::ST_IDLE))
    else $error("request ready outside idle");

  a_push_not_popped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |-> (grns_pkg::add_mod3(pb_q, dcost_q) != pb_q))
    else $error("push into the bucket being popped");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == grns_pkg::ST_POP ||
                            $past(state_q) == grns_pkg::ST_RCHK))
    else $error("result raised outside search end");

  a_probe_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grns_pkg::ST_ECHK) |-> (dcost_q == 2'd1 || dcost_q == 2'd2))
    else $error("bad expansion cost");
`endif

endmodule

// ===== tb/sv/grid_nearest_road_search_top_tb.sv =====
module grid_nearest_road_search_top_tb;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int CELLS  = GRID_W * GRID_H;

  typedef struct packed {
    logic                          found;
    logic [grns_pkg::COORD_W-1:0]  road_x;
    logic [grns_pkg::COORD_W-1:0]  road_y;
  } road_res_t;

  typedef struct {
    int          x;
    int          y;
    int unsigned cost;
  } front_t;

  typedef struct {
    logic                         req;
    logic [grns_pkg::COORD_W-1:0] x;
    logic [grns_pkg::COORD_W-1:0] y;
    logic                         open_b;
    logic                         road_b;
    bit                           typed;
    road_res_t                    res;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  grns_req_if req_if ();
  grns_res_if res_if ();
  grns_cfg_if cfg_if ();

  grid_nearest_road_search_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the block state
  bit          open_grid [CELLS];
  bit          road_grid [CELLS];
  int unsigned width_reg  = 64;
  int unsigned height_reg = 64;

  road_res_t   road_exp_q[$];
  stim_row_t   dir_rows[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int fail_cnt   = 0;
  int n_results  = 0;
  int n_searches = 0;
  int n_writes   = 0;
  int n_found    = 0;

  // least-cost search over the shadow maps
  function automatic road_res_t predict_road(int sx, int sy);
    bit          seen [CELLS];
    front_t      frontier[$];
    front_t      cur;
    front_t      nxt;
    road_res_t   r;
    int          w;
    int          h;
    int          best;
    int          nx;
    int          ny;
    int          rdx[4];
    int          rdy[4];
    int          edx[8];
    int          edy[8];
    rdx = '{0, 0, 1, -1};
    rdy = '{1, -1, 0, 0};
    edx = '{1, 0, -1, 0, 1, 1, -1, -1};
    edy = '{0, -1, 0, 1, 1, -1, -1, 1};
    w = (width_reg > GRID_W) ? GRID_W : int'(width_reg);
    h = (height_reg > GRID_H) ? GRID_H : int'(height_reg);
    r = '0;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[sy * GRID_W + sx] = 1'b1;
    cur.x = sx; cur.y = sy; cur.cost = 0;
    frontier = {frontier, cur};
    while (frontier.size() > 0) begin
      best = 0;
      for (int i = 1; i < frontier.size(); i++)
        if (frontier[i].cost < frontier[best].cost) best = i;
      cur = frontier[best];
      frontier.delete(best);
      for (int k = 0; k < 4; k++) begin
        nx = cur.x + rdx[k];
        ny = cur.y + rdy[k];
        if (nx >= 0 && ny >= 0 && nx < w && ny < h && road_grid[ny * GRID_W + nx]) begin
          r.found  = 1'b1;
          r.road_x = nx[grns_pkg::COORD_W-1:0];
          r.road_y = ny[grns_pkg::COORD_W-1:0];
          return r;
        end
      end
      for (int k = 0; k < 8; k++) begin
        nx = cur.x + edx[k];
        ny = cur.y + edy[k];
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        if (!open_grid[ny * GRID_W + nx] || seen[ny * GRID_W + nx]) continue;
        seen[ny * GRID_W + nx] = 1'b1;
        nxt.x = nx; nxt.y = ny;
        nxt.cost = cur.cost + (edx[k] != 0) + (edy[k] != 0);
        frontier = {frontier, nxt};
      end
    end
    return r;
  endfunction

  // one request transaction, with random idle cycles ahead of it
  task automatic send_req(input logic req, input int x, input int y, input logic o,
                          input logic rd, input bit typed, input road_res_t tres);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= req;
    req_if.cell_x    <= x[grns_pkg::COORD_W-1:0];
    req_if.cell_y    <= y[grns_pkg::COORD_W-1:0];
    req_if.cell_open <= o;
    req_if.cell_road <= rd;
    do @(posedge clk_i); while (!req_if.ready);
    if (req == grns_pkg::REQ_WRITE) begin
      open_grid[y * GRID_W + x] = o;
      road_grid[y * GRID_W + x] = rd;
      n_writes++;
    end else begin
      road_exp_q.insert(road_exp_q.size(), typed ? tres : predict_road(x, y));
      n_searches++;
    end
  endtask

  // register write, only once the block has drained; valid is dropped by the caller
  task automatic write_reg(input logic [grns_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[grns_pkg::DIM_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == grns_pkg::REG_MAP_WIDTH) width_reg = 32'(val[grns_pkg::DIM_W-1:0]);
    else if (idx == grns_pkg::REG_MAP_HEIGHT) height_reg = 32'(val[grns_pkg::DIM_W-1:0]);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    wait (road_exp_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_row(input logic req, input int x, input int y, input logic o,
                         input logic rd, input bit typed, input logic f,
                         input int rx, input int ry);
    stim_row_t row;
    row.req = req;
    row.x = x[grns_pkg::COORD_W-1:0];
    row.y = y[grns_pkg::COORD_W-1:0];
    row.open_b = o; row.road_b = rd;
    row.typed = typed;
    row.res.found  = f;
    row.res.road_x = rx[grns_pkg::COORD_W-1:0];
    row.res.road_y = ry[grns_pkg::COORD_W-1:0];
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // pick a map size: mostly tiny, sometimes the extremes
  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return 64;
    if (sel == 2) return 127;
    if (sel == 3) return $urandom_range(65, 126);
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_coord();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 9);
  endfunction

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    road_res_t e;
    if (res_if.valid && res_if.ready) begin
      n_results++;
      if (road_exp_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_cnt++;
      end else begin
        e = road_exp_q.pop_front();
        if (res_if.found !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, res_if.found);
          fail_cnt++;
        end
        if (res_if.road_x !== e.road_x) begin
          $error("road_x: expected %0d actual %0d", e.road_x, res_if.road_x);
          fail_cnt++;
        end
        if (res_if.road_y !== e.road_y) begin
          $error("road_y: expected %0d actual %0d", e.road_y, res_if.road_y);
          fail_cnt++;
        end
        if (e.found) n_found++;
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 12000;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int px [4];
    int sx [4];
    int w;
    int h;
    px = '{0, 62, 0, 23};
    sx = '{0, 0, 62, 23};
    req_if.valid = 1'b0;
    req_if.req_type = grns_pkg::REQ_WRITE;
    req_if.cell_x = '0;
    req_if.cell_y = '0;
    req_if.cell_open = 1'b0;
    req_if.cell_road = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (open_grid[i]) begin
      open_grid[i] = 1'b0;
      road_grid[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at reset size 64 x 64
    add_row(grns_pkg::REQ_SEARCH, 0, 0, 0, 0, 1, 0, 0, 0);     // empty map: not found
    add_row(grns_pkg::REQ_WRITE, 1, 0, 0, 1, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_SEARCH, 0, 0, 0, 0, 1, 1, 1, 0);     // road right of a closed start
    add_row(grns_pkg::REQ_WRITE, 63, 63, 1, 1, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_SEARCH, 63, 62, 0, 0, 1, 1, 63, 63); // far corner road
    add_row(grns_pkg::REQ_SEARCH, 63, 63, 0, 0, 0, 0, 0, 0);   // start on a road itself
    add_row(grns_pkg::REQ_WRITE, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_WRITE, 0, 2, 1, 0, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_WRITE, 1, 3, 1, 1, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_WRITE, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0);     // walk up an open column
    add_row(grns_pkg::REQ_WRITE, 2, 2, 0, 1, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_WRITE, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_SEARCH, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_WRITE, 63, 0, 1, 1, 0, 0, 0, 0);
    add_row(grns_pkg::REQ_SEARCH, 62, 0, 0, 0, 1, 1, 63, 0);   // top edge start, road at x+1
    add_row(grns_pkg::REQ_SEARCH, 0, 3, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].x, dir_rows[i].y, dir_rows[i].open_b,
               dir_rows[i].road_b, dir_rows[i].typed, dir_rows[i].res);

    // random episodes: size the map, scatter cells, then search it
    for (int ph = 0; ph < 4; ph++) begin
      for (int ep = 0; ep < 3; ep++) begin
        drain();
        idle_pct  = px[ph];
        stall_pct = sx[ph];
        w = pick_dim();
        h = pick_dim();
        if (ph == 3 && ep == 2) begin
          w = 127;
          h = 127;
        end
        // small map so the first search ends well inside the hold-off
        if (ph == 0 && ep == 1) begin
          w = 4;
          h = 4;
        end
        write_reg(grns_pkg::REG_MAP_WIDTH, w);
        write_reg(grns_pkg::REG_MAP_HEIGHT, h);
        if ($urandom_range(0, 3) == 0)
          write_reg(grns_pkg::CFG_IDX_W'($urandom_range(2, 255)), $urandom_range(0, 127));
        cfg_if.valid <= 1'b0;
        // long receiver hold-off while searches keep coming
        if (ph == 0 && ep == 1) hold_token++;
        for (int i = 0; i < 6; i++)
          send_req(grns_pkg::REQ_WRITE, pick_coord(), pick_coord(),
                   $urandom_range(0, 3) != 0, $urandom_range(0, 6) == 0, 0, '0);
        for (int i = 0; i < 2; i++)
          send_req(grns_pkg::REQ_SEARCH, pick_coord(), pick_coord(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d map writes and %0d searches, %0d results with %0d roads found",
             n_writes, n_searches, n_results, n_found);
    $display("map sizes from zero to oversized, four idle and stall mixes");
    if (fail_cnt == 0 && road_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
